FILE: src/rrts_pkg.sv
// Shared types and codes of the round-robin thread scheduler.
`default_nettype none
package rrts_pkg;

  localparam int DEF_MAX_THREADS = 8;
  localparam int DEF_HANDLE_BITS = 8;

  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SWITCH = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ALREADY  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_KEY,
    S_FIND,
    S_HIT,
    S_SHIFT,
    S_RMFIN,
    S_PMOD,
    S_PSCAN,
    S_PEND,
    S_NH,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: src/rrts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/round_robin_thread_scheduler.sv
// Round-robin thread scheduler: thread table, command sequencer and result register.
// Add, context switch and unknown commands go from decode to the result without a scan; a tick
// scans one slot per cycle, and remove, sleep and wake search, shift and rescan one slot per
// cycle. One command at a time: the next is accepted as the result appears, once the result
// register is free. rst clears flags, counts, slots and out_valid, not handles.
`default_nettype none
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS,
  parameter int HANDLE_BITS = rrts_pkg::DEF_HANDLE_BITS,
  localparam int SW = $clog2(MAX_THREADS + 2)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rrts_pkg::CMD_W-1:0]  command,
  input  wire logic [HANDLE_BITS-1:0]      thread_id,
  input  wire logic                        use_running,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [rrts_pkg::STAT_W-1:0] status,
  output logic                             switch_needed,
  output logic      [SW-1:0]               next_slot,
  output logic      [HANDLE_BITS-1:0]      next_thread,
  output logic      [SW-1:0]               running_slot_out,
  output logic      [SW-1:0]               thread_count
);
  import rrts_pkg::*;

  // The handle table lives in a RAM indexed directly by slot number; slot 0
  // is the idle slot and its entry is never read for a result.
  localparam int RAM_DEPTH = MAX_THREADS + 1;
  localparam int AW = $clog2(RAM_DEPTH);
  localparam logic [SW-1:0] MAX_SLOT = SW'(MAX_THREADS);
  localparam logic [SW-1:0] ONE = SW'(1);
  localparam logic [SW-1:0] ZERO = '0;

  state_t state, state_next;

  // Command transaction held for the whole sequence; S_KEY replaces the key with the running handle.
  logic [CMD_W-1:0]       cmd, cmd_next;
  logic [HANDLE_BITS-1:0] key, key_next;
  logic                   use_run, use_run_next;

  // Architectural scheduler state.
  logic [SW-1:0]          cnt, cnt_next;
  logic [SW-1:0]          running, running_next;
  logic [SW-1:0]          chosen, chosen_next;
  logic [MAX_THREADS:0]   rdy, rdy_next;

  // Sequencer working registers: one slot pointer shared by the search,
  // the shift, the modulo reduction and the round-robin scan.
  logic [SW-1:0]          ptr, ptr_next;
  logic [SW-1:0]          iter, iter_next;
  logic [SW-1:0]          tgt, tgt_next;
  logic [SW-1:0]          rd_slot, rd_slot_next;
  logic                   cmp_v, cmp_v_next;
  logic                   keep, keep_next;
  logic [STAT_W-1:0]      stat, stat_next;
  logic                   sw, sw_next;

  // RAM port.
  logic                   ram_we;
  logic [SW-1:0]          ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic [SW-1:0]          ram_raddr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  // Shared compare results.
  logic                   hit;
  logic                   ptr_past;
  logic                   ptr_rdy;
  logic                   tgt_rdy;
  logic                   run_ready;
  logic                   out_free;
  logic                   out_load;
  logic [SW-1:0]          slot_add;
  logic [HANDLE_BITS-1:0] nh;

  rrts_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_handles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign hit       = cmp_v && (ram_rdata == key);
  assign ptr_past  = (ptr > cnt);
  assign ptr_rdy   = (ptr <= MAX_SLOT) ? rdy[ptr] : 1'b0;
  assign tgt_rdy   = (tgt <= MAX_SLOT) ? rdy[tgt] : 1'b0;
  // The idle slot is always ready; a running slot beyond the count is empty.
  assign run_ready = (running == ZERO) ||
                     ((running <= cnt) && (running <= MAX_SLOT) && rdy[running]);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_OUT) && out_free;
  assign slot_add  = cnt + ONE;
  assign nh        = ((chosen != ZERO) && (chosen <= cnt)) ? ram_rdata : '0;

  // Next-state logic of the command sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd) inside
          CMD_TICK: state_next = S_PMOD;
          CMD_REMOVE, CMD_SLEEP, CMD_WAKE: begin
            if (use_run && ((running == ZERO) || (running > cnt))) begin
              state_next = S_NH;
            end else if (use_run) begin
              state_next = S_KEY;
            end else begin
              state_next = S_FIND;
            end
          end
          default: state_next = S_NH;
        endcase
      end
      S_KEY: state_next = S_FIND;
      S_FIND: begin
        if (hit) begin
          state_next = S_HIT;
        end else if (ptr_past) begin
          state_next = S_NH;
        end
      end
      S_HIT: begin
        if (cmd == CMD_REMOVE) begin
          state_next = S_SHIFT;
        end else if ((cmd == CMD_SLEEP) && tgt_rdy && (tgt == running)) begin
          state_next = S_PMOD;
        end else begin
          state_next = S_NH;
        end
      end
      S_SHIFT: begin
        if (ptr_past) begin
          state_next = S_RMFIN;
        end
      end
      S_RMFIN: state_next = (running == tgt) ? S_PMOD : S_NH;
      S_PMOD: begin
        if (cnt == ZERO) begin
          state_next = S_PEND;
        end else if (ptr < cnt) begin
          state_next = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (ptr_rdy) begin
          state_next = S_NH;
        end else if (iter == cnt - ONE) begin
          state_next = S_PEND;
        end
      end
      S_PEND: state_next = S_NH;
      S_NH:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and RAM control for each sequencer step.
  always_comb begin
    cmd_next     = cmd;
    key_next     = key;
    use_run_next = use_run;
    cnt_next     = cnt;
    running_next = running;
    chosen_next  = chosen;
    rdy_next     = rdy;
    ptr_next     = ptr;
    iter_next    = iter;
    tgt_next     = tgt;
    rd_slot_next = rd_slot;
    cmp_v_next   = cmp_v;
    keep_next    = keep;
    stat_next    = stat;
    sw_next      = sw;
    ram_we       = 1'b0;
    ram_waddr    = slot_add;
    ram_wdata    = key;
    ram_raddr    = chosen;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next     = command;
          key_next     = thread_id;
          use_run_next = use_running;
          stat_next    = STAT_OK;
          sw_next      = 1'b0;
        end
      end
      S_DECODE: begin
        unique case (cmd) inside
          CMD_TICK: begin
            ptr_next  = running;
            keep_next = 1'b1;
          end
          CMD_ADD: begin
            if (cnt >= MAX_SLOT) begin
              stat_next = STAT_FULL;
            end else begin
              ram_we             = 1'b1;
              rdy_next[slot_add] = 1'b1;
              cnt_next           = slot_add;
            end
          end
          CMD_REMOVE, CMD_SLEEP, CMD_WAKE: begin
            ram_raddr  = running;
            ptr_next   = ONE;
            cmp_v_next = 1'b0;
            if (use_run && (running == ZERO)) begin
              stat_next = (cmd == CMD_WAKE) ? STAT_ALREADY : STAT_NOTFOUND;
            end else if (use_run && (running > cnt)) begin
              stat_next = STAT_NOTFOUND;
            end
          end
          CMD_SWITCH: begin
            running_next = chosen;
            chosen_next  = running;
          end
          default: begin
          end
        endcase
      end
      S_KEY: key_next = ram_rdata;
      S_FIND: begin
        ram_raddr    = ptr;
        rd_slot_next = ptr;
        if (hit) begin
          tgt_next = rd_slot;
        end else if (ptr_past) begin
          stat_next = STAT_NOTFOUND;
        end else begin
          ptr_next   = ptr + ONE;
          cmp_v_next = 1'b1;
        end
      end
      S_HIT: begin
        unique case (cmd) inside
          CMD_REMOVE: begin
            ptr_next   = tgt + ONE;
            cmp_v_next = 1'b0;
            for (int k = 1; k < MAX_THREADS; k++) begin
              if ((SW'(k) >= tgt) && (SW'(k) < cnt)) begin
                rdy_next[k] = rdy[k+1];
              end
            end
          end
          CMD_SLEEP: begin
            if (!tgt_rdy) begin
              stat_next = STAT_ALREADY;
            end else begin
              rdy_next[tgt] = 1'b0;
              ptr_next      = running;
              keep_next     = 1'b1;
            end
          end
          default: begin
            if (tgt_rdy) begin
              stat_next = STAT_ALREADY;
            end else begin
              rdy_next[tgt] = 1'b1;
            end
          end
        endcase
      end
      S_SHIFT: begin
        ram_raddr    = ptr;
        rd_slot_next = ptr;
        ram_waddr    = rd_slot - ONE;
        ram_wdata    = ram_rdata;
        ram_we       = cmp_v;
        if (!ptr_past) begin
          ptr_next   = ptr + ONE;
          cmp_v_next = 1'b1;
        end
      end
      S_RMFIN: begin
        cnt_next = cnt - ONE;
        if (running == tgt) begin
          chosen_next = ZERO;
          ptr_next    = tgt - ONE;
          keep_next   = 1'b0;
        end else begin
          if (running > tgt) begin
            running_next = running - ONE;
          end
          if (chosen > tgt) begin
            chosen_next = chosen - ONE;
          end
        end
      end
      S_PMOD: begin
        if (cnt != ZERO) begin
          if (ptr >= cnt) begin
            ptr_next = ptr - cnt;
          end else begin
            ptr_next  = ptr + ONE;
            iter_next = ZERO;
          end
        end
      end
      S_PSCAN: begin
        if (ptr_rdy) begin
          chosen_next = ptr;
          sw_next     = 1'b1;
        end else begin
          ptr_next  = (ptr == cnt) ? ONE : ptr + ONE;
          iter_next = iter + ONE;
        end
      end
      S_PEND: begin
        if (keep && run_ready) begin
          sw_next = 1'b0;
        end else begin
          chosen_next = ZERO;
          sw_next     = 1'b1;
        end
      end
      S_NH: begin
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= ZERO;
      running <= ZERO;
      chosen  <= ZERO;
      rdy     <= (MAX_THREADS + 1)'(1);
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      running <= running_next;
      chosen  <= chosen_next;
      rdy     <= rdy_next;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    key     <= key_next;
    use_run <= use_run_next;
    ptr     <= ptr_next;
    iter    <= iter_next;
    tgt     <= tgt_next;
    rd_slot <= rd_slot_next;
    cmp_v   <= cmp_v_next;
    keep    <= keep_next;
    stat    <= stat_next;
    sw      <= sw_next;
  end

  // Result register: holds one finished transaction while the next command
  // is already being accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status           <= stat;
      switch_needed    <= sw;
      next_slot        <= chosen;
      next_thread      <= nh;
      running_slot_out <= running;
      thread_count     <= cnt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_SLOT)
    else $error("thread count exceeds table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_FULL)) |-> (thread_count == MAX_SLOT))
    else $error("table full reported with free slots");

  a_scan_needs_threads: assert property (@(posedge clk) disable iff (rst)
    (state == S_PSCAN) |-> (cnt != ZERO))
    else $error("round-robin scan over an empty table");

  a_already_no_switch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_ALREADY)) |-> !switch_needed)
    else $error("switch requested on a no-op sleep or wake");

  a_busy_holds_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");
`endif

endmodule
`default_nettype wire
